FILE: hdl/cnep_pkg.sv
package cnep_pkg;

    // Width of the size fields that the block accepts; larger values are format errors.
    localparam int SIZE_BITS = 32;

    localparam int HEADER_LEN  = 110;
    localparam int MODE_AT     = 14;
    localparam int FSIZE_AT    = 54;
    localparam int NSIZE_AT    = 94;
    localparam int HEX_DIGITS  = 8;
    localparam int TYPE_SHIFT  = 12;
    localparam int TRAILER_LEN = 11;

    localparam int POS_W  = 7;
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        K_HEADER = 3'd0,
        K_NAME   = 3'd1,
        K_DATA   = 3'd2,
        K_END    = 3'd3,
        K_ERROR  = 3'd4
    } kind_t;

    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [7:0]          byte_value;
        logic [3:0]          file_type;
        logic [WORD_W-1:0]   entry_size;
        logic [WORD_W-1:0]   entry_name_length;
        logic                last_of_run;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.val = 4'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]}) begin
            h.val = 4'(c - 8'h57);
        end
        else if (c inside {[8'h41:8'h46]}) begin
            h.val = 4'(c - 8'h37);
        end
        else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Characters of the end-of-archive name, including its terminating zero.
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h54;
            4'd1:    c = 8'h52;
            4'd2:    c = 8'h41;
            4'd3:    c = 8'h49;
            4'd4:    c = 8'h4C;
            4'd5:    c = 8'h45;
            4'd6:    c = 8'h52;
            4'd7:    c = 8'h21;
            4'd8:    c = 8'h21;
            4'd9:    c = 8'h21;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/cnep_in_reg.sv
module cnep_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // The register can take a new byte whenever it is empty or its current byte moves on this cycle.
    assign s_tready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

endmodule

FILE: hdl/cnep_parser.sv
module cnep_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       in_byte,
    output cnep_pkg::result_t res
);
    import cnep_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_NAME_PAD,
        PH_DATA,
        PH_DATA_PAD,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [1:0]        pad;
        logic [WORD_W-1:0] rem;
    } move_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic [3:0]         ftype_reg, ftype_next;
    logic [WORD_W-1:0]  dsize_reg, dsize_next;
    logic [WORD_W-1:0]  nsize_reg, nsize_next;
    logic [WORD_W-1:0]  rem_reg, rem_next;
    logic [1:0]         pad_reg, pad_next;
    logic               match_reg, match_next;

    function automatic move_t enter_data(input logic [WORD_W-1:0] ds, input logic [1:0] pad_in,
                                         input logic [WORD_W-1:0] rem_in);
        move_t m;
        logic [1:0] dpad;
        dpad  = 2'(2'd0 - ds[1:0]);
        m.pad = pad_in;
        m.rem = rem_in;
        if (ds != '0)
        begin
            m.phase = PH_DATA;
            m.rem   = ds;
        end
        else
        begin
            m.pad   = dpad;
            m.phase = (dpad != 2'd0) ? PH_DATA_PAD : PH_HEADER;
        end
        return m;
    endfunction

    function automatic move_t enter_name_pad(input logic [WORD_W-1:0] ns,
                                             input logic [WORD_W-1:0] ds,
                                             input logic [WORD_W-1:0] rem_in);
        move_t m;
        logic [1:0] npad;
        npad = 2'(2'd2 - ns[1:0]);
        if (npad != 2'd0)
        begin
            m.phase = PH_NAME_PAD;
            m.pad   = npad;
            m.rem   = rem_in;
        end
        else
        begin
            m = enter_data(ds, npad, rem_in);
        end
        return m;
    endfunction

    hex_digit_t        digit;
    logic              in_field;
    logic [POS_W-1:0]  field_start;
    logic [WORD_W-1:0] acc_step;
    logic [WORD_W-1:0] name_idx;
    logic [WORD_W-1:0] rem_dec;
    logic [1:0]        pad_dec;
    move_t             mv;

    assign digit    = hex_decode(in_byte);
    assign name_idx = nsize_reg - rem_reg;
    assign rem_dec  = rem_reg - WORD_W'(1);
    assign pad_dec  = pad_reg - 2'd1;

    always_comb
    begin
        in_field    = 1'b0;
        field_start = POS_W'(MODE_AT);
        if (pos_reg >= POS_W'(MODE_AT) && pos_reg < POS_W'(MODE_AT + HEX_DIGITS))
        begin
            in_field    = 1'b1;
            field_start = POS_W'(MODE_AT);
        end
        if (pos_reg >= POS_W'(FSIZE_AT) && pos_reg < POS_W'(FSIZE_AT + HEX_DIGITS))
        begin
            in_field    = 1'b1;
            field_start = POS_W'(FSIZE_AT);
        end
        if (pos_reg >= POS_W'(NSIZE_AT) && pos_reg < POS_W'(NSIZE_AT + HEX_DIGITS))
        begin
            in_field    = 1'b1;
            field_start = POS_W'(NSIZE_AT);
        end
        acc_step = (pos_reg == field_start) ? WORD_W'(digit.val)
                                            : {acc_reg[WORD_W-5:0], digit.val};
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        ftype_next = ftype_reg;
        dsize_next = dsize_reg;
        nsize_next = nsize_reg;
        rem_next   = rem_reg;
        pad_next   = pad_reg;
        match_next = match_reg;
        mv         = '{phase: phase_reg, pad: pad_reg, rem: rem_reg};

        res = '0;
        res.kind = K_HEADER;

        case (phase_reg)
            PH_HEADER:
            begin
                if (in_field && !digit.ok)
                begin
                    phase_next = PH_ERROR;
                    res.valid  = 1'b1;
                    res.kind   = K_ERROR;
                end
                else
                begin
                    if (in_field)
                    begin
                        acc_next = acc_step;
                    end
                    if (in_field && pos_reg == field_start + POS_W'(HEX_DIGITS - 1)
                        && field_start != POS_W'(MODE_AT)
                        && (64'(acc_step) >> SIZE_BITS) != 64'd0)
                    begin
                        phase_next = PH_ERROR;
                        res.valid  = 1'b1;
                        res.kind   = K_ERROR;
                    end
                    else
                    begin
                        if (in_field && pos_reg == field_start + POS_W'(HEX_DIGITS - 1))
                        begin
                            if (field_start == POS_W'(MODE_AT))
                            begin
                                ftype_next = acc_step[TYPE_SHIFT+3:TYPE_SHIFT];
                            end
                            else if (field_start == POS_W'(FSIZE_AT))
                            begin
                                dsize_next = acc_step;
                            end
                            else
                            begin
                                nsize_next = acc_step;
                            end
                        end
                        if (pos_reg >= POS_W'(HEADER_LEN - 1))
                        begin
                            res.valid             = 1'b1;
                            res.kind              = K_HEADER;
                            res.file_type         = ftype_reg;
                            res.entry_size        = dsize_reg;
                            res.entry_name_length = nsize_reg;
                            match_next            = 1'b1;
                            pos_next              = '0;
                            if (nsize_reg != '0)
                            begin
                                mv = '{phase: PH_NAME, pad: pad_reg, rem: nsize_reg};
                            end
                            else
                            begin
                                mv = enter_name_pad(nsize_reg, dsize_reg, rem_reg);
                            end
                            phase_next = mv.phase;
                            pad_next   = mv.pad;
                            rem_next   = mv.rem;
                        end
                        else
                        begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end
                end
            end

            PH_NAME:
            begin
                if (name_idx < WORD_W'(TRAILER_LEN) && in_byte != trailer_char(name_idx[3:0]))
                begin
                    match_next = 1'b0;
                end
                rem_next  = rem_dec;
                res.valid = 1'b1;
                if (rem_dec == '0 && match_next && nsize_reg >= WORD_W'(TRAILER_LEN))
                begin
                    phase_next = PH_DONE;
                    res.kind   = K_END;
                end
                else
                begin
                    res.kind       = K_NAME;
                    res.byte_value = in_byte;
                    if (rem_dec == '0)
                    begin
                        res.last_of_run = 1'b1;
                        mv = enter_name_pad(nsize_reg, dsize_reg, rem_dec);
                        phase_next = mv.phase;
                        pad_next   = mv.pad;
                        rem_next   = mv.rem;
                    end
                end
            end

            PH_NAME_PAD:
            begin
                pad_next = pad_dec;
                if (pad_dec == 2'd0)
                begin
                    mv = enter_data(dsize_reg, pad_dec, rem_reg);
                    phase_next = mv.phase;
                    pad_next   = mv.pad;
                    rem_next   = mv.rem;
                    pos_next   = '0;
                end
            end

            PH_DATA:
            begin
                res.valid      = 1'b1;
                res.kind       = K_DATA;
                res.byte_value = in_byte;
                rem_next       = rem_dec;
                if (rem_dec == '0)
                begin
                    res.last_of_run = 1'b1;
                    pad_next   = 2'(2'd0 - dsize_reg[1:0]);
                    phase_next = (pad_next != 2'd0) ? PH_DATA_PAD : PH_HEADER;
                    pos_next   = '0;
                end
            end

            PH_DATA_PAD:
            begin
                pad_next = pad_dec;
                if (pad_dec == 2'd0)
                begin
                    phase_next = PH_HEADER;
                    pos_next   = '0;
                end
            end

            default:
            begin
                // Done or error: every further byte is dropped.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            acc_reg   <= '0;
            ftype_reg <= '0;
            dsize_reg <= '0;
            nsize_reg <= '0;
            rem_reg   <= '0;
            pad_reg   <= '0;
            match_reg <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            ftype_reg <= ftype_next;
            dsize_reg <= dsize_next;
            nsize_reg <= nsize_next;
            rem_reg   <= rem_next;
            pad_reg   <= pad_next;
            match_reg <= match_next;
        end
    end

endmodule

FILE: hdl/cpio_newc_entry_parser.sv
// Byte-serial parser for newc cpio archives.
// Input channel s_*: one archive byte per transfer in s_tdata.
// Output channel m_*: at most one result per input byte. m_tuser is the result
// kind (header, name byte, data byte, end of archive, format error), m_tlast
// marks the final byte of a name or data run, and m_tdata carries the byte and,
// on header results, the file type and the data and name sizes.
// Header bytes and padding bytes outside the results are consumed silently.
// Throughput: one byte per cycle unless the receiver stalls the output, set by a
// single pass of the parser logic between the input register and the output register.
// Each byte is held in the input register; its result is held in the output register behind m_tvalid.
// Reset empties both registers and returns the parser to the start of a header.
// After end of archive or a format error, bytes are accepted and dropped
// until the next reset.
// When the receiver holds m_tready low, the output register holds its result,
// the input register fills with one more byte, and then s_tready drops.
module cpio_newc_entry_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // archive_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // byte_value, file_type, entry_size, entry_name_length, zeros
    output logic [2:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last_of_run
);
    import cnep_pkg::*;

    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       fire;
    result_t    step_res;
    result_t    out_reg;
    result_t    out_next;

    assign advance = !out_reg.valid || m_tready;
    assign fire    = byte_valid && advance;

    cnep_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .advance   (advance),
        .byte_valid(byte_valid),
        .byte_data (byte_data)
    );

    cnep_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .in_byte(byte_data),
        .res    (step_res)
    );

    always_comb
    begin
        out_next       = step_res;
        out_next.valid = fire && step_res.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_of_run;
    assign m_tdata  = {4'd0, out_reg.entry_name_length, out_reg.entry_size,
                       out_reg.file_type, out_reg.byte_value};

endmodule

FILE: hdl/cnep_checker.sv
module cnep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import cnep_pkg::*;

    // A stalled result must hold.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("result changed while stalled");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == K_NAME || m_tuser == K_DATA)
        else $error("last flag on a result that is not a name or data byte");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != K_NAME && m_tuser != K_DATA |-> m_tdata[7:0] == 8'd0)
        else $error("byte value set on a non-byte result");

    a_final_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == K_END || m_tuser == K_ERROR) |-> m_tdata == '0 && !m_tlast)
        else $error("end or error result carries payload");

    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == K_END || m_tuser == K_ERROR) |=> !m_tvalid)
        else $error("result after end of archive or format error");

endmodule

bind cpio_newc_entry_parser cnep_checker u_cnep_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cnep_pkg::*;

    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_NAME,
        SCAN_NAME_PAD,
        SCAN_DATA,
        SCAN_DATA_PAD,
        SCAN_DONE,
        SCAN_ERROR
    } scan_phase_t;

    typedef enum int {
        END_EXACT_TRAILER,
        END_LONG_TRAILER,
        END_BAD_DIGIT,
        END_HUGE_SIZE
    } archive_end_t;

    typedef struct {
        kind_t             kind;
        logic [7:0]        value;
        logic [3:0]        ftype;
        logic [WORD_W-1:0] fsize;
        logic [WORD_W-1:0] nsize;
        logic              last;
    } parse_result_t;

    localparam int          RANDOM_BYTES = 100;
    localparam int          TAIL_BYTES   = 16;
    localparam int          HOLD_AT      = 150;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CALM_FROM    = 250;
    localparam int          CALM_TO      = 450;
    localparam int          IDLE_PERCENT = 29;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          REPORT_MAX   = 10;
    localparam logic [31:0] NO_CAP       = 32'hFFFF_FFFF;
    localparam logic [8*TRAILER_LEN-1:0] TRAILER_TEXT = {"TRAILER!!!", 8'h00};

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;   // byte_value, file_type, entry_size, entry_name_length, zeros
    logic [2:0]  m_tuser;   // result_kind
    logic        m_tlast;   // last_of_run

    cpio_newc_entry_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    logic [7:0]    archive_q[$];
    logic [7:0]    name_q[$];
    parse_result_t expected_q[$];

    int           bytes_in        = 0;
    int           hold_count      = 0;
    int           results_checked = 0;
    int           failures        = 0;
    int           kind_seen[5]    = '{default: 0};
    archive_end_t archive_end;

    // Predictor state.
    scan_phase_t       phase       = SCAN_HEADER;
    int                hdr_pos     = 0;
    logic [WORD_W-1:0] acc         = '0;
    logic [3:0]        held_type   = '0;
    logic [WORD_W-1:0] held_fsize  = '0;
    logic [WORD_W-1:0] held_nsize  = '0;
    logic [WORD_W-1:0] remaining   = '0;
    logic [1:0]        pad         = '0;
    logic              name_matches = 1'b1;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    wire calm    = bytes_in >= CALM_FROM && bytes_in < CALM_TO;
    wire holding = bytes_in >= HOLD_AT && hold_count < HOLD_CYCLES;

    // Returns the digit value in the low bits and a valid flag in bit 4.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return {1'b1, 4'(c - "0")};
        end
        if (c >= "a" && c <= "f")
        begin
            return {1'b1, 4'(c - "a" + 8'd10)};
        end
        if (c >= "A" && c <= "F")
        begin
            return {1'b1, 4'(c - "A" + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic bit size_fits(input logic [WORD_W-1:0] v);
        return (64'(v) >> SIZE_BITS) == 64'd0;
    endfunction

    function automatic void start_header();
        phase   = SCAN_HEADER;
        hdr_pos = 0;
    endfunction

    function automatic void start_data_pad();
        pad = 2'd0 - held_fsize[1:0];
        if (pad != 2'd0)
        begin
            phase = SCAN_DATA_PAD;
        end
        else
        begin
            start_header();
        end
    endfunction

    function automatic void start_data();
        if (held_fsize != '0)
        begin
            phase     = SCAN_DATA;
            remaining = held_fsize;
        end
        else
        begin
            start_data_pad();
        end
    endfunction

    // Name padding is counted from the start of the 110-byte header.
    function automatic void start_name_pad();
        pad = 2'd2 - held_nsize[1:0];
        if (pad != 2'd0)
        begin
            phase = SCAN_NAME_PAD;
        end
        else
        begin
            start_data();
        end
    endfunction

    function automatic void push_format_error();
        parse_result_t r;
        r = '{kind: K_ERROR, value: '0, ftype: '0, fsize: '0, nsize: '0, last: 1'b0};
        phase = SCAN_ERROR;
        expected_q.push_back(r);
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        parse_result_t     r;
        logic [4:0]        digit;
        int                field_at;
        logic [WORD_W-1:0] idx;
        r = '{kind: K_HEADER, value: '0, ftype: '0, fsize: '0, nsize: '0, last: 1'b0};
        case (phase)
            SCAN_HEADER:
            begin
                field_at = -1;
                if (hdr_pos >= MODE_AT && hdr_pos < MODE_AT + HEX_DIGITS)
                begin
                    field_at = MODE_AT;
                end
                if (hdr_pos >= FSIZE_AT && hdr_pos < FSIZE_AT + HEX_DIGITS)
                begin
                    field_at = FSIZE_AT;
                end
                if (hdr_pos >= NSIZE_AT && hdr_pos < NSIZE_AT + HEX_DIGITS)
                begin
                    field_at = NSIZE_AT;
                end
                if (field_at >= 0)
                begin
                    digit = hex_nibble(b);
                    if (!digit[4])
                    begin
                        push_format_error();
                        return;
                    end
                    if (hdr_pos == field_at)
                    begin
                        acc = WORD_W'(digit[3:0]);
                    end
                    else
                    begin
                        acc = {acc[WORD_W-5:0], digit[3:0]};
                    end
                    if (hdr_pos == field_at + HEX_DIGITS - 1)
                    begin
                        if (field_at == MODE_AT)
                        begin
                            held_type = acc[TYPE_SHIFT +: 4];
                        end
                        else if (!size_fits(acc))
                        begin
                            push_format_error();
                            return;
                        end
                        else if (field_at == FSIZE_AT)
                        begin
                            held_fsize = acc;
                        end
                        else
                        begin
                            held_nsize = acc;
                        end
                    end
                end
                if (hdr_pos >= HEADER_LEN - 1)
                begin
                    r.ftype = held_type;
                    r.fsize = held_fsize;
                    r.nsize = held_nsize;
                    expected_q.push_back(r);
                    name_matches = 1'b1;
                    hdr_pos      = 0;
                    if (held_nsize != '0)
                    begin
                        phase     = SCAN_NAME;
                        remaining = held_nsize;
                    end
                    else
                    begin
                        start_name_pad();
                    end
                end
                else
                begin
                    hdr_pos++;
                end
            end
            SCAN_NAME:
            begin
                idx = held_nsize - remaining;
                if (idx < TRAILER_LEN &&
                    b != TRAILER_TEXT[8*(TRAILER_LEN-1-int'(idx)) +: 8])
                begin
                    name_matches = 1'b0;
                end
                remaining--;
                r.kind  = K_NAME;
                r.value = b;
                if (remaining == '0)
                begin
                    if (name_matches && held_nsize >= TRAILER_LEN)
                    begin
                        r.kind  = K_END;
                        r.value = '0;
                        phase   = SCAN_DONE;
                    end
                    else
                    begin
                        r.last = 1'b1;
                        start_name_pad();
                    end
                end
                expected_q.push_back(r);
            end
            SCAN_NAME_PAD:
            begin
                pad = pad - 2'd1;
                if (pad == 2'd0)
                begin
                    start_data();
                end
            end
            SCAN_DATA:
            begin
                r.kind  = K_DATA;
                r.value = b;
                remaining--;
                if (remaining == '0)
                begin
                    r.last = 1'b1;
                    start_data_pad();
                end
                expected_q.push_back(r);
            end
            SCAN_DATA_PAD:
            begin
                pad = pad - 2'd1;
                if (pad == 2'd0)
                begin
                    start_header();
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Eight hex digits, most significant first, each letter in a random case.
    task automatic push_hex_field(input logic [31:0] v);
        logic [3:0] nib;
        for (int k = 7; k >= 0; k--)
        begin
            nib = v[4*k +: 4];
            if (nib < 4'd10)
            begin
                archive_q.push_back(8'("0") + 8'(nib));
            end
            else if ($urandom_range(1) == 1)
            begin
                archive_q.push_back(8'("a") + 8'(nib) - 8'd10);
            end
            else
            begin
                archive_q.push_back(8'("A") + 8'(nib) - 8'd10);
            end
        end
    endtask

    task automatic push_header(input logic [31:0] mode, input logic [31:0] fsize,
                               input logic [31:0] nsize);
        string magic;
        magic = "070701";
        for (int i = 0; i < 6; i++)
        begin
            archive_q.push_back($urandom_range(3) != 0 ? magic[i] : 8'($urandom_range(255)));
        end
        for (int f = 0; f < 13; f++)
        begin
            if (f == 1)
            begin
                push_hex_field(mode);
            end
            else if (f == 6)
            begin
                push_hex_field(fsize);
            end
            else if (f == 11)
            begin
                push_hex_field(nsize);
            end
            else if ($urandom_range(1) == 1)
            begin
                push_hex_field($urandom);
            end
            else
            begin
                // The parser does not look at these fields, so anything goes.
                for (int k = 0; k < 8; k++)
                begin
                    archive_q.push_back(8'($urandom_range(255)));
                end
            end
        end
    endtask

    task automatic set_name(input string s);
        name_q.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            name_q.push_back(s[i]);
        end
    endtask

    task automatic set_random_name(input int len);
        name_q.delete();
        for (int i = 0; i < len; i++)
        begin
            name_q.push_back(8'($urandom_range(255)));
        end
    endtask

    // Name bytes come from name_q, then a zero, then random filler. A run longer than
    // cap is cut short, and nothing after it in the entry is sent.
    task automatic push_entry(input logic [31:0] mode, input logic [31:0] fsize,
                              input logic [31:0] nsize, input logic [31:0] cap);
        logic [31:0] n_sent;
        logic [1:0]  n_pad;
        push_header(mode, fsize, nsize);
        n_sent = nsize < cap ? nsize : cap;
        for (int unsigned i = 0; i < n_sent; i++)
        begin
            if (i < name_q.size())
            begin
                archive_q.push_back(name_q[i]);
            end
            else if (i == name_q.size())
            begin
                archive_q.push_back(8'h00);
            end
            else
            begin
                archive_q.push_back(8'($urandom_range(255)));
            end
        end
        if (n_sent != nsize)
        begin
            return;
        end
        n_pad = 2'd2 - nsize[1:0];
        for (int i = 0; i < n_pad; i++)
        begin
            archive_q.push_back(8'($urandom_range(255)));
        end
        n_sent = fsize < cap ? fsize : cap;
        for (int unsigned i = 0; i < n_sent; i++)
        begin
            archive_q.push_back(8'($urandom_range(255)));
        end
        if (n_sent != fsize)
        begin
            return;
        end
        n_pad = 2'd0 - fsize[1:0];
        for (int i = 0; i < n_pad; i++)
        begin
            archive_q.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic check_result();
        parse_result_t want;
        if (expected_q.size() == 0)
        begin
            note_failure($sformatf("unexpected result: kind=%0d tdata=%h last=%b",
                                   m_tuser, m_tdata, m_tlast));
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        kind_seen[int'(want.kind)]++;
        if (m_tuser !== want.kind || m_tdata[7:0] !== want.value ||
            m_tdata[11:8] !== want.ftype || m_tdata[43:12] !== want.fsize ||
            m_tdata[75:44] !== want.nsize || m_tdata[79:76] !== 4'd0 ||
            m_tlast !== want.last)
        begin
            note_failure($sformatf(
                "result %0d: expected kind=%0d byte=%h type=%h size=%h name_len=%h last=%b",
                results_checked, want.kind, want.value, want.ftype, want.fsize,
                want.nsize, want.last));
            if (failures <= REPORT_MAX)
            begin
                $display("    got kind=%0d byte=%h type=%h size=%h name_len=%h last=%b pad=%h",
                         m_tuser, m_tdata[7:0], m_tdata[11:8], m_tdata[43:12],
                         m_tdata[75:44], m_tlast, m_tdata[79:76]);
            end
        end
    endtask

    // Archive bytes go out from archive_q; each accepted transfer feeds the predictor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata);
                bytes_in <= bytes_in + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (archive_q.size() > 0 &&
                    (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= archive_q.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long back-pressure window, so the parser fills and stalls its input.
    always @(posedge clk)
    begin
        if (rst_n && holding)
        begin
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            m_tready <= !holding && (calm || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        int          random_start;
        int          base;
        int          pick;
        logic [7:0]  bad;
        logic [4:0]  probe;
        logic [31:0] fsize;
        logic [31:0] nsize;

        // Directed entries: empty name and data, extreme modes, short names that look
        // like the trailer without matching it.
        set_name("");
        push_entry(32'h0000_81A4, 32'd0, 32'd0, NO_CAP);
        set_name("a");
        push_entry(32'hFFFF_FFFF, 32'd1, 32'd2, NO_CAP);
        set_name("");
        push_entry(32'h0000_0000, 32'd4, 32'd1, NO_CAP);
        set_name("TRAILER!!!");
        push_entry(32'h0000_A1FF, 32'd3, 32'd10, NO_CAP);
        set_name("TRAILER!!!x");
        push_entry(32'h0000_41ED, 32'd0, 32'd11, NO_CAP);

        random_start = archive_q.size();
        while (archive_q.size() - random_start < RANDOM_BYTES)
        begin
            fsize = $urandom_range(4) == 0 ? 32'd0 : 32'($urandom_range(40));
            nsize = $urandom_range(5) == 0 ? 32'd0 : 32'($urandom_range(20, 1));
            set_random_name(nsize == 0 ? 0 : int'(nsize) - 1);
            push_entry($urandom, fsize, nsize, NO_CAP);
        end

        // Only one way to close the archive fits in a run, since reset comes once.
        archive_end = archive_end_t'($urandom_range(3));
        case (archive_end)
            END_EXACT_TRAILER:
            begin
                set_name("TRAILER!!!");
                push_entry($urandom, 32'($urandom_range(8)), 32'd11, NO_CAP);
            end
            END_LONG_TRAILER:
            begin
                set_name("TRAILER!!!");
                push_entry($urandom, 32'($urandom_range(8)), 32'($urandom_range(20, 12)),
                           NO_CAP);
            end
            END_BAD_DIGIT:
            begin
                base = archive_q.size();
                push_header($urandom, 32'($urandom_range(8)), 32'($urandom_range(8)));
                pick = $urandom_range(2);
                do
                begin
                    bad   = 8'($urandom_range(255));
                    probe = hex_nibble(bad);
                end
                while (probe[4]);
                archive_q[base + (pick == 0 ? MODE_AT : pick == 1 ? FSIZE_AT : NSIZE_AT)
                          + $urandom_range(HEX_DIGITS - 1)] = bad;
            end
            default:
            begin
                set_random_name(3);
                if ($urandom_range(1) == 1)
                begin
                    push_entry($urandom, {1'b1, 31'($urandom)}, 32'd4, 32'd40);
                end
                else
                begin
                    push_entry($urandom, 32'd2, {1'b1, 31'($urandom)}, 32'd40);
                end
            end
        endcase
        for (int i = 0; i < TAIL_BYTES; i++)
        begin
            archive_q.push_back(8'($urandom_range(255)));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (archive_q.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d archive bytes, closed by %s; checked %0d results:",
                 bytes_in, archive_end.name(), results_checked);
        $display("  %0d headers, %0d name bytes, %0d data bytes, %0d end, %0d format errors.",
                 kind_seen[K_HEADER], kind_seen[K_NAME], kind_seen[K_DATA],
                 kind_seen[K_END], kind_seen[K_ERROR]);
        if (failures == 0)
        begin
            $display("cpio_newc_entry_parser regression: pass");
        end
        else
        begin
            $display("%0d failing results", failures);
            $display("cpio_newc_entry_parser regression: fail");
        end
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("timeout with %0d results still expected", expected_q.size());
        $display("cpio_newc_entry_parser regression: fail");
        $finish;
    end

endmodule
